[hdl/mdh_fk_pkg.sv]
package mdh_fk_pkg;

    localparam int CORDIC_STEPS = 17;

    typedef logic signed [15:0] t_ang;
    typedef logic signed [31:0] t_q30;
    typedef logic signed [33:0] t_tv;
    typedef logic signed [39:0] t_pos;
    typedef t_q30 t_mat [3][3];
    typedef t_pos t_pvec [3];
    typedef t_tv t_tvec [3];

    typedef enum logic [7:0] {
        CFG_TWIST_LO = 8'd0,
        CFG_TWIST_HI = 8'd1,
        CFG_LEN_LO   = 8'd2,
        CFG_LEN_HI   = 8'd3,
        CFG_OFS_LO   = 8'd4,
        CFG_OFS_HI   = 8'd5
    } t_cfg_reg;

    localparam logic signed [21:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        22'sd262144, 22'sd154753, 22'sd81767, 22'sd41506, 22'sd20834, 22'sd10427,
        22'sd5215, 22'sd2608, 22'sd1304, 22'sd652, 22'sd326, 22'sd163, 22'sd81,
        22'sd41, 22'sd20, 22'sd10, 22'sd5
    };

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam t_q30 ONE_Q30 = 32'sd1073741824;
    localparam t_mat ROT_IDENT = '{
        '{ONE_Q30, 32'sd0, 32'sd0},
        '{32'sd0, ONE_Q30, 32'sd0},
        '{32'sd0, 32'sd0, ONE_Q30}
    };

    localparam logic [63:0] RST_TWIST_LO = 64'hC000_4000_C000_0000;
    localparam logic [47:0] RST_TWIST_HI = 48'h4000_C000_4000;
    localparam logic [63:0] RST_LEN_LO   = 64'h0;
    localparam logic [47:0] RST_LEN_HI   = 48'h0;
    localparam logic [63:0] RST_OFS_LO   = 64'h0000_0A5E_0000_0C00;
    localparam logic [47:0] RST_OFS_HI   = 48'h08D5_0000_0A5E;

    function automatic logic signed [37:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] prod;
        begin
            prod = a * b + 68'sd536870912;
            return prod[67:30];
        end
    endfunction

    function automatic t_q30 sat_q30(input logic signed [33:0] v);
        begin
            if (v > 34'sd1073741824) begin
                return ONE_Q30;
            end else if (v < -34'sd1073741824) begin
                return -ONE_Q30;
            end
            return v[31:0];
        end
    endfunction

endpackage

[hdl/mdh_fk_if.sv]
interface mdh_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] angle_j0;
    logic signed [15:0] angle_j1;
    logic signed [15:0] angle_j2;
    logic signed [15:0] angle_j3;
    logic signed [15:0] angle_j4;
    logic signed [15:0] angle_j5;
    logic signed [15:0] angle_j6;
    modport source (output valid, output angle_j0, output angle_j1, output angle_j2,
                    output angle_j3, output angle_j4, output angle_j5, output angle_j6,
                    input ready);
    modport sink (input valid, input angle_j0, input angle_j1, input angle_j2,
                  input angle_j3, input angle_j4, input angle_j5, input angle_j6,
                  output ready);
endinterface

interface mdh_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    modport source (output valid, output rot_00, output rot_01, output rot_02,
                    output rot_10, output rot_11, output rot_12, output rot_20,
                    output rot_21, output rot_22, output pos_x, output pos_y,
                    output pos_z, input ready);
    modport sink (input valid, input rot_00, input rot_01, input rot_02,
                  input rot_10, input rot_11, input rot_12, input rot_20,
                  input rot_21, input rot_22, input pos_x, input pos_y,
                  input pos_z, output ready);
endinterface

interface mdh_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  addr;
    logic [63:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

[hdl/mdh_cordic.sv]
module mdh_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  mdh_fk_pkg::t_ang   i_angle,
    output mdh_fk_pkg::t_q30   o_cos,
    output mdh_fk_pkg::t_q30   o_sin
);
    import mdh_fk_pkg::*;

    logic signed [32:0] r_x [CORDIC_STEPS];
    logic signed [32:0] r_y [CORDIC_STEPS];
    logic signed [21:0] r_z [CORDIC_STEPS];
    logic [1:0]         r_q [CORDIC_STEPS];
    t_q30               r_cos;
    t_q30               r_sin;
    t_q30               n_cx;
    t_q30               n_cy;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            logic signed [32:0] x_in;
            logic signed [32:0] y_in;
            logic signed [21:0] z_in;
            logic [1:0]         q_in;
            if (i == 0) begin : g_first
                assign x_in = CORDIC_GAIN;
                assign y_in = 33'sd0;
                assign z_in = {3'b000, i_angle[13:0], 5'b00000};
                assign q_in = i_angle[15:14];
            end else begin : g_next
                assign x_in = r_x[i-1];
                assign y_in = r_y[i-1];
                assign z_in = r_z[i-1];
                assign q_in = r_q[i-1];
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[i] <= q_in;
                    if (z_in >= 22'sd0) begin
                        r_x[i] <= x_in - (y_in >>> i);
                        r_y[i] <= y_in + (x_in >>> i);
                        r_z[i] <= z_in - CORDIC_ATAN[i];
                    end else begin
                        r_x[i] <= x_in + (y_in >>> i);
                        r_y[i] <= y_in - (x_in >>> i);
                        r_z[i] <= z_in + CORDIC_ATAN[i];
                    end
                end
            end
        end
    endgenerate

    assign n_cx = sat_q30(34'(r_x[CORDIC_STEPS-1]));
    assign n_cy = sat_q30(34'(r_y[CORDIC_STEPS-1]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STEPS-1])
                2'd0: begin
                    r_cos <= n_cx;
                    r_sin <= n_cy;
                end
                2'd1: begin
                    r_cos <= -n_cy;
                    r_sin <= n_cx;
                end
                2'd2: begin
                    r_cos <= -n_cx;
                    r_sin <= -n_cy;
                end
                default: begin
                    r_cos <= n_cy;
                    r_sin <= -n_cx;
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[hdl/mdh_link.sv]
module mdh_link #(
    parameter int DELAY = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  mdh_fk_pkg::t_ang  i_angle,
    input  mdh_fk_pkg::t_ang  i_twist,
    input  mdh_fk_pkg::t_ang  i_len,
    input  mdh_fk_pkg::t_ang  i_ofs,
    input  mdh_fk_pkg::t_mat  i_rot,
    input  mdh_fk_pkg::t_pvec i_pos,
    output mdh_fk_pkg::t_mat  o_rot,
    output mdh_fk_pkg::t_pvec o_pos
);
    import mdh_fk_pkg::*;

    t_ang  w_ang;
    t_q30  w_ct;
    t_q30  w_st;
    t_q30  w_ca;
    t_q30  w_sa;
    t_q30  w_dd;
    t_mat  n_a;
    t_tvec n_t;
    t_mat  r_a;
    t_tvec r_t;
    t_q30  n_pr [3][3][3];
    t_tv   n_pq [3][3];
    t_q30  r_pr [3][3][3];
    t_tv   r_pq [3][3];
    t_pvec r_pm;
    t_mat  n_rot;
    t_pvec n_pos;
    t_mat  r_rot;
    t_pvec r_pos;

    generate
        if (DELAY > 0) begin : g_dly
            t_ang r_dly [DELAY];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dly[0] <= i_angle;
                    for (int k = 1; k < DELAY; k++) begin
                        r_dly[k] <= r_dly[k-1];
                    end
                end
            end
            assign w_ang = r_dly[DELAY-1];
        end else begin : g_nodly
            assign w_ang = i_angle;
        end
    endgenerate

    mdh_cordic u_joint (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (w_ang),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    mdh_cordic u_twist (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (i_twist),
        .o_cos   (w_ca),
        .o_sin   (w_sa)
    );

    assign w_dd = {i_ofs, 16'h0000};

    always_comb begin
        logic signed [37:0] m10, m11, m20, m21, m1, m2;
        m10 = mulq(34'(w_st), 34'(w_ca));
        m11 = mulq(34'(w_ct), 34'(w_ca));
        m20 = mulq(34'(w_st), 34'(w_sa));
        m21 = mulq(34'(w_ct), 34'(w_sa));
        m1  = mulq(34'(w_dd), 34'(w_sa));
        m2  = mulq(34'(w_dd), 34'(w_ca));
        n_a[0][0] = w_ct;
        n_a[0][1] = -w_st;
        n_a[0][2] = 32'sd0;
        n_a[1][0] = m10[31:0];
        n_a[1][1] = m11[31:0];
        n_a[1][2] = -w_sa;
        n_a[2][0] = m20[31:0];
        n_a[2][1] = m21[31:0];
        n_a[2][2] = w_ca;
        n_t[0] = 34'(i_len) <<< 16;
        n_t[1] = -m1[33:0];
        n_t[2] = m2[33:0];
    end

    always_comb begin
        logic signed [37:0] m;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                m = mulq(34'(i_rot[r][k]), r_t[k]);
                n_pq[r][k] = m[33:0];
                for (int c = 0; c < 3; c++) begin
                    m = mulq(34'(i_rot[r][k]), 34'(r_a[k][c]));
                    n_pr[r][c][k] = m[31:0];
                end
            end
        end
    end

    always_comb begin
        logic signed [33:0] acc;
        logic signed [35:0] ps;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = 34'(r_pr[r][c][0]) + 34'(r_pr[r][c][1]) + 34'(r_pr[r][c][2]);
                n_rot[r][c] = sat_q30(acc);
            end
            ps = 36'(r_pq[r][0]) + 36'(r_pq[r][1]) + 36'(r_pq[r][2]);
            n_pos[r] = r_pm[r] + 40'(ps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_t   <= n_t;
            r_pr  <= n_pr;
            r_pq  <= n_pq;
            r_pm  <= i_pos;
            r_rot <= n_rot;
            r_pos <= n_pos;
        end
    end

    assign o_rot = r_rot;
    assign o_pos = r_pos;

endmodule

[hdl/mdh_forward_kinematics.sv]
// Modified-DH forward kinematics for a serial arm of up to seven revolute joints. An item
// of seven joint angles enters in every cycle unless the output stalls; the chain has
// as many links as the smaller of JOINT_COUNT and seven. Each joint takes sine and cosine
// from a 17-stage CORDIC plus one clamp stage, one stage builds the link transform, and
// the chain spends two stages per link (products, then sums) before one rounding stage.
// A stalled output holds the whole pipeline in place. Configuration
// writes are always accepted and must only be made while no item is in flight.
module mdh_forward_kinematics #(
    parameter int JOINT_COUNT = 7
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mdh_in_if.sink     i_in,
    mdh_out_if.source  o_out,
    mdh_cfg_if.sink    i_cfg
);
    import mdh_fk_pkg::*;

    localparam int LINKS = (JOINT_COUNT < 7) ? JOINT_COUNT : 7;
    localparam int LAT   = 2 * LINKS + 20;

    logic [63:0] r_tw_lo;
    logic [47:0] r_tw_hi;
    logic [63:0] r_len_lo;
    logic [47:0] r_len_hi;
    logic [63:0] r_ofs_lo;
    logic [47:0] r_ofs_hi;
    logic [LAT-1:0] r_vld;
    logic        w_en;
    t_ang        w_ang [7];
    t_mat        w_rot [LINKS+1];
    t_pvec       w_pos [LINKS+1];
    logic signed [15:0] r_rot [3][3];
    logic signed [23:0] r_pos [3];

    function automatic logic signed [15:0] round_rot(input t_q30 v);
        logic signed [32:0] s;
        logic signed [16:0] h;
        begin
            s = 33'(v) + 33'sd32768;
            h = s[32:16];
            if (h > 17'sd16384) begin
                return 16'sd16384;
            end else if (h < -17'sd16384) begin
                return -16'sd16384;
            end
            return h[15:0];
        end
    endfunction

    function automatic logic signed [23:0] round_pos(input t_pos v);
        logic signed [40:0] s;
        logic signed [24:0] h;
        begin
            s = 41'(v) + 41'sd32768;
            h = s[40:16];
            if (h > 25'sd8388607) begin
                return 24'sd8388607;
            end else if (h < -25'sd8388608) begin
                return -24'sd8388608;
            end
            return h[23:0];
        end
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw_lo  <= RST_TWIST_LO;
            r_tw_hi  <= RST_TWIST_HI;
            r_len_lo <= RST_LEN_LO;
            r_len_hi <= RST_LEN_HI;
            r_ofs_lo <= RST_OFS_LO;
            r_ofs_hi <= RST_OFS_HI;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_TWIST_LO: r_tw_lo  <= i_cfg.data;
                CFG_TWIST_HI: r_tw_hi  <= i_cfg.data[47:0];
                CFG_LEN_LO:   r_len_lo <= i_cfg.data;
                CFG_LEN_HI:   r_len_hi <= i_cfg.data[47:0];
                CFG_OFS_LO:   r_ofs_lo <= i_cfg.data;
                CFG_OFS_HI:   r_ofs_hi <= i_cfg.data[47:0];
                default: ;
            endcase
        end
    end

    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    assign w_ang[0] = i_in.angle_j0;
    assign w_ang[1] = i_in.angle_j1;
    assign w_ang[2] = i_in.angle_j2;
    assign w_ang[3] = i_in.angle_j3;
    assign w_ang[4] = i_in.angle_j4;
    assign w_ang[5] = i_in.angle_j5;
    assign w_ang[6] = i_in.angle_j6;

    assign w_rot[0] = ROT_IDENT;
    assign w_pos[0] = '{40'sd0, 40'sd0, 40'sd0};

    genvar j;
    generate
        for (j = 0; j < LINKS; j++) begin : g_link
            t_ang w_tw;
            t_ang w_len;
            t_ang w_ofs;
            if (j < 4) begin : g_lo
                assign w_tw  = r_tw_lo[16*j +: 16];
                assign w_len = r_len_lo[16*j +: 16];
                assign w_ofs = r_ofs_lo[16*j +: 16];
            end else begin : g_hi
                assign w_tw  = r_tw_hi[16*(j-4) +: 16];
                assign w_len = r_len_hi[16*(j-4) +: 16];
                assign w_ofs = r_ofs_hi[16*(j-4) +: 16];
            end
            mdh_link #(
                .DELAY (2 * j)
            ) u_link (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_angle (w_ang[j]),
                .i_twist (w_tw),
                .i_len   (w_len),
                .i_ofs   (w_ofs),
                .i_rot   (w_rot[j]),
                .i_pos   (w_pos[j]),
                .o_rot   (w_rot[j+1]),
                .o_pos   (w_pos[j+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_rot[r][c] <= round_rot(w_rot[LINKS][r][c]);
                end
                r_pos[r] <= round_pos(w_pos[LINKS][r]);
            end
        end
    end

    assign o_out.valid  = r_vld[LAT-1];
    assign o_out.rot_00 = r_rot[0][0];
    assign o_out.rot_01 = r_rot[0][1];
    assign o_out.rot_02 = r_rot[0][2];
    assign o_out.rot_10 = r_rot[1][0];
    assign o_out.rot_11 = r_rot[1][1];
    assign o_out.rot_12 = r_rot[1][2];
    assign o_out.rot_20 = r_rot[2][0];
    assign o_out.rot_21 = r_rot[2][1];
    assign o_out.rot_22 = r_rot[2][2];
    assign o_out.pos_x  = r_pos[0];
    assign o_out.pos_y  = r_pos[1];
    assign o_out.pos_z  = r_pos[2];

`ifndef NO_ASSERTIONS
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline stalled");
`endif

endmodule

[tb/mdh_fk_checker.sv]
`timescale 1ns / 1ps

module mdh_fk_checker
    import mdh_fk_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mdh_in_if         i_in,
    mdh_out_if        i_out,
    mdh_cfg_if        i_cfg,
    output int        o_errors,
    output int        o_pending
);

    localparam int LINK_COUNT = 7;
    localparam longint ONE = 64'sd1073741824;
    localparam longint ATAN_TAB [17] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215,
                                         2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [23:0] pos [3];
    } t_pose;

    logic [63:0] regs [6];
    t_pose       pose_q [$];

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint joint_field(int pair, int j);
        logic [63:0] r;
        logic signed [15:0] f;
        r = regs[pair * 2 + (j < 4 ? 0 : 1)];
        f = r[16 * (j % 4) +: 16];
        return longint'(f);
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        logic [1:0] quad;
        quad = ang[15:14];
        z = longint'(ang[13:0]) <<< 5;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 17; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        x = clampl(x, -ONE, ONE);
        y = clampl(y, -ONE, ONE);
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_pose(input logic [15:0] ang [7], output t_pose res);
        longint rm [3][3];
        longint nm [3][3];
        longint am [3][3];
        longint p [3];
        longint t [3];
        longint ct, st, ca, sa, a, d, acc, v;
        for (int r = 0; r < 3; r++) begin
            p[r] = 0;
            for (int c = 0; c < 3; c++) begin
                rm[r][c] = (r == c) ? ONE : 0;
            end
        end
        for (int j = 0; j < LINK_COUNT; j++) begin
            a = joint_field(1, j);
            d = joint_field(2, j);
            sin_cos(ang[j], ct, st);
            sin_cos(16'(joint_field(0, j)), ca, sa);
            am[0][0] = ct; am[0][1] = -st; am[0][2] = 0;
            am[1][0] = qmul(st, ca); am[1][1] = qmul(ct, ca); am[1][2] = -sa;
            am[2][0] = qmul(st, sa); am[2][1] = qmul(ct, sa); am[2][2] = ca;
            t[0] = a * 65536;
            t[1] = -qmul(d * 65536, sa);
            t[2] = qmul(d * 65536, ca);
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    p[r] += qmul(rm[r][k], t[k]);
                end
                for (int c = 0; c < 3; c++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) begin
                        acc += qmul(rm[r][k], am[k][c]);
                    end
                    nm[r][c] = clampl(acc, -ONE, ONE);
                end
            end
            rm = nm;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                v = clampl((rm[r][c] + 32768) >>> 16, -16384, 16384);
                res.rot[r * 3 + c] = 16'(v);
            end
            v = clampl((p[r] + 32768) >>> 16, -8388608, 8388607);
            res.pos[r] = 24'(v);
        end
    endtask

    always @(posedge i_clk) begin
        logic [15:0] ang [7];
        t_pose got, want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            regs[CFG_TWIST_LO] <= RST_TWIST_LO;
            regs[CFG_TWIST_HI] <= {16'h0, RST_TWIST_HI};
            regs[CFG_LEN_LO]   <= RST_LEN_LO;
            regs[CFG_LEN_HI]   <= {16'h0, RST_LEN_HI};
            regs[CFG_OFS_LO]   <= RST_OFS_LO;
            regs[CFG_OFS_HI]   <= {16'h0, RST_OFS_HI};
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready && i_cfg.addr < 6) begin
                regs[i_cfg.addr] <= i_cfg.addr[0] ? {16'h0, i_cfg.data[47:0]} : i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                ang = '{i_in.angle_j0, i_in.angle_j1, i_in.angle_j2, i_in.angle_j3,
                        i_in.angle_j4, i_in.angle_j5, i_in.angle_j6};
                predict_pose(ang, want);
                pose_q.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                got.rot = '{i_out.rot_00, i_out.rot_01, i_out.rot_02, i_out.rot_10,
                            i_out.rot_11, i_out.rot_12, i_out.rot_20, i_out.rot_21,
                            i_out.rot_22};
                got.pos = '{i_out.pos_x, i_out.pos_y, i_out.pos_z};
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose result", $time);
                    bad = bad + 1;
                end else begin
                    want = pose_q.pop_front();
                    for (int i = 0; i < 9; i++) begin
                        if (got.rot[i] !== want.rot[i]) begin
                            $display("%0t: rot[%0d] expected %0d actual %0d", $time, i,
                                     want.rot[i], got.rot[i]);
                            bad = bad + 1;
                        end
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (got.pos[i] !== want.pos[i]) begin
                            $display("%0t: pos[%0d] expected %0d actual %0d", $time, i,
                                     want.pos[i], got.pos[i]);
                            bad = bad + 1;
                        end
                    end
                end
            end
            o_errors <= o_errors + bad;
            o_pending <= pose_q.size();
        end
    end

endmodule

[tb/mdh_forward_kinematics_tb.sv]
`timescale 1ns / 1ps

module mdh_forward_kinematics_tb;
    import mdh_fk_pkg::*;

    localparam int LATENCY = 34;
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   hold_req;
    bit   stim_done;

    mdh_in_if  in_ch ();
    mdh_out_if out_ch ();
    mdh_cfg_if cfg_ch ();

    mdh_forward_kinematics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    mdh_fk_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls at random, with calm stretches and one long hold-off.
    initial begin
        int hold_off;
        bit hold_taken;
        hold_off = 0;
        hold_taken = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                hold_off = hold_off - 1;
                out_ch.ready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_off = 199;
                out_ch.ready <= 1'b0;
            end else if (($time / 20000) % 3 == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] value);
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_angles(input logic [15:0] a [7]);
        in_ch.angle_j0 <= a[0];
        in_ch.angle_j1 <= a[1];
        in_ch.angle_j2 <= a[2];
        in_ch.angle_j3 <= a[3];
        in_ch.angle_j4 <= a[4];
        in_ch.angle_j5 <= a[5];
        in_ch.angle_j6 <= a[6];
        in_ch.valid    <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_burst(input int count, input int mode);
        logic [15:0] a [7];
        int gap;
        gap = 0;
        for (int n = 0; n < count; n++) begin
            for (int j = 0; j < 7; j++) begin
                case (mode)
                    0: a[j] = 16'($urandom);
                    1: a[j] = (n % 2) ? 16'h7FFF : 16'h8000;
                    default: a[j] = 16'($urandom_range(0, 3)) << 14;
                endcase
            end
            send_angles(a);
            if (gap == 0) begin
                gap = $urandom_range(1, 24);
                if ($urandom_range(0, 2) == 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            gap--;
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [63:0] tw_lo, input logic [47:0] tw_hi,
                             input logic [63:0] ln_lo, input logic [47:0] ln_hi,
                             input logic [63:0] of_lo, input logic [47:0] of_hi);
        write_reg(CFG_TWIST_LO, tw_lo);
        write_reg(CFG_TWIST_HI, {16'hFFFF, tw_hi});
        write_reg(CFG_LEN_LO, ln_lo);
        write_reg(CFG_LEN_HI, {16'hA5A5, ln_hi});
        write_reg(CFG_OFS_LO, of_lo);
        write_reg(CFG_OFS_HI, {16'h5A5A, of_hi});
    endtask

    initial begin
        logic [15:0] a [7];
        stim_done = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.angle_j0 = '0;
        in_ch.angle_j1 = '0;
        in_ch.angle_j2 = '0;
        in_ch.angle_j3 = '0;
        in_ch.angle_j4 = '0;
        in_ch.angle_j5 = '0;
        in_ch.angle_j6 = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        a = '{default: 16'h0000};
        send_angles(a);
        a = '{default: 16'h7FFF};
        send_angles(a);
        a = '{default: 16'h8000};
        send_angles(a);
        a = '{default: 16'hFFFF};
        send_angles(a);
        a = '{16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h0001, 16'h3FFF, 16'h5555};
        send_angles(a);
        in_ch.valid <= 1'b0;
        send_burst(10, 2);
        send_burst(6, 1);
        send_burst(300, 0);

        // Long receiver hold-off while items keep coming.
        hold_req <= 1'b1;
        send_burst(150, 0);
        drain();

        write_all(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  48'h7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
        write_reg(t_cfg_reg'(8'd9), 64'h1234);
        send_burst(200, 0);
        send_burst(4, 1);
        drain();

        write_all(64'h8000_8000_8000_8000, 48'h8000_8000_8000, 64'h8000_8000_8000_8000,
                  48'h8000_8000_8000, 64'h8000_8000_8000_8000, 48'h8000_8000_8000);
        send_burst(200, 0);
        drain();

        write_all({$urandom, $urandom}, 48'({$urandom, $urandom}), {$urandom, $urandom},
                  48'({$urandom, $urandom}), {$urandom, $urandom},
                  48'({$urandom, $urandom}));
        send_burst(200, 0);
        drain();

        write_all(64'h0000_0000_0000_0000, 48'h0, 64'h0000_1000_F000_0800,
                  48'h0400_FC00_0200, 64'h0000_0000_0000_0000, 48'h0);
        send_burst(250, 0);
        send_burst(8, 2);
        drain();
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        wait (stim_done || idle_cycles >= WATCHDOG_LIMIT);
        if (stim_done && errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
